/* src/lwpp_pkg.sv */
// shared types, codes and constants of the lcd window pixel word packer
`timescale 1ns / 1ps

package lwpp_pkg;

    // pixels in one display row, upper bound of a line start width
    localparam int ROW_PIXELS = 132;

    // default depth of the queue between front and back
    localparam int Q_DEPTH = 4;

    // input item kinds as they arrive in tuser
    localparam logic [1:0] KIND_LINE  = 2'd0;
    localparam logic [1:0] KIND_PAIR  = 2'd1;
    localparam logic [1:0] KIND_PIXEL = 2'd2;

    // queued operation codes
    localparam logic [1:0] OP_LINE  = 2'd0;
    localparam logic [1:0] OP_PAIR  = 2'd1;
    localparam logic [1:0] OP_PIXEL = 2'd2;

    // index of the final word of each operation
    localparam logic [3:0] LAST_IDX_LINE  = 4'd6;
    localparam logic [3:0] LAST_IDX_PAIR  = 4'd2;
    localparam logic [3:0] LAST_IDX_PIXEL = 4'd9;

    // word positions inside an address window sequence
    localparam logic [3:0] W_PAGE_CMD = 4'd0;
    localparam logic [3:0] W_ROW_A    = 4'd1;
    localparam logic [3:0] W_ROW_B    = 4'd2;
    localparam logic [3:0] W_COL_CMD  = 4'd3;
    localparam logic [3:0] W_COL0     = 4'd4;
    localparam logic [3:0] W_COL1     = 4'd5;
    localparam logic [3:0] W_RAMWR    = 4'd6;
    localparam logic [3:0] W_PIX_HI   = 4'd7;
    localparam logic [3:0] W_PIX_LO   = 4'd8;
    localparam logic [3:0] W_NOP      = 4'd9;

    // configuration register indexes
    localparam logic [1:0] REG_PAGE_SET = 2'd0;
    localparam logic [1:0] REG_COL_SET  = 2'd1;
    localparam logic [1:0] REG_RAM_WR   = 2'd2;
    localparam logic [1:0] REG_NOP      = 2'd3;

    // register reset values
    localparam logic [7:0] RST_PAGE_SET = 8'd117;
    localparam logic [7:0] RST_COL_SET  = 8'd21;
    localparam logic [7:0] RST_RAM_WR   = 8'd92;
    localparam logic [7:0] RST_NOP      = 8'd37;

    // one queued operation
    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  col0;
        logic [7:0]  col1;
        logic [7:0]  row;
        logic [11:0] c1;
        logic [11:0] c2;
    } t_op;

    // command bytes handed to the back end
    typedef struct packed {
        logic [7:0] page_set;
        logic [7:0] col_set;
        logic [7:0] ram_wr;
        logic [7:0] nop;
    } t_opcodes;

endpackage

/* src/lwpp_front.sv */
// front end: accepts request beats, checks them, tracks the open line, queues work
`timescale 1ns / 1ps

module lwpp_front
    import lwpp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [47:0] i_data,
    input  logic        i_full,
    output logic        o_push,
    output t_op         o_op
);

    logic [7:0]  col_start;
    logic [7:0]  row_index;
    logic [7:0]  line_width;
    logic [11:0] first_color;
    logic [11:0] second_color;
    logic        accept;
    logic        width_ok;
    logic [7:0]  pairs_dec;
    logic [7:0]  r_pairs, n_pairs;
    logic        r_open, n_open;

    // unpack the request fields
    assign col_start    = i_data[7:0];
    assign row_index    = i_data[15:8];
    assign line_width   = i_data[23:16];
    assign first_color  = i_data[35:24];
    assign second_color = i_data[47:36];

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    assign width_ok  = (line_width != 8'd0) && (line_width <= 8'(ROW_PIXELS));
    assign pairs_dec = (r_pairs != 8'd0) ? r_pairs - 8'd1 : 8'd0;

    // classify the beat and compute the next line state
    always_comb begin
        o_push       = 1'b0;
        o_op.op      = OP_LINE;
        o_op.col0    = col_start;
        o_op.col1    = col_start + line_width - 8'd1;
        o_op.row     = row_index;
        o_op.c1      = first_color;
        o_op.c2      = second_color;
        n_pairs      = r_pairs;
        n_open       = r_open;
        case (i_kind)
            KIND_LINE: begin
                if (width_ok) begin
                    o_push  = accept;
                    o_op.op = OP_LINE;
                    if (accept) begin
                        n_pairs = {1'b0, line_width[7:1]} + {7'd0, line_width[0]};
                        n_open  = 1'b1;
                    end
                end
            end
            KIND_PAIR: begin
                if (r_open) begin
                    o_push  = accept;
                    o_op.op = OP_PAIR;
                    if (accept) begin
                        n_pairs = pairs_dec;
                        n_open  = (pairs_dec != 8'd0);
                    end
                end
            end
            KIND_PIXEL: begin
                o_push    = accept;
                o_op.op   = OP_PIXEL;
                o_op.col1 = col_start;
                if (accept) begin
                    n_pairs = 8'd0;
                    n_open  = 1'b0;
                end
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

    // line state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pairs <= 8'd0;
            r_open  <= 1'b0;
        end else begin
            r_pairs <= n_pairs;
            r_open  <= n_open;
        end
    end

    // an open line always has pairs left, a closed one none
    a_open_pairs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open == (r_pairs != 8'd0))
        else $error("line open flag disagrees with pair count");

endmodule

/* src/lwpp_fifo.sv */
// short operation queue between front and back
`timescale 1ns / 1ps

module lwpp_fifo
    import lwpp_pkg::*;
#(
    parameter int DEPTH = Q_DEPTH
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_op  o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

    t_op             r_mem [DEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule

/* src/lwpp_back.sv */
// back end: expands ops to 9-bit words, one per cycle unless stalled
`timescale 1ns / 1ps

module lwpp_back
    import lwpp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_opcodes   i_opc,
    input  logic       i_q_valid,
    input  t_op        i_q_op,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_is_data,
    output logic [7:0] o_byte,
    output logic       o_last
);

    logic [3:0] r_idx;
    logic [3:0] last_idx;
    logic       load;
    logic       w_is_data;
    logic [7:0] w_byte;
    logic       w_last;
    logic       r_valid;
    logic       r_is_data;
    logic [7:0] r_byte;
    logic       r_last;

    assign load  = i_q_valid && (!r_valid || i_ready);
    assign o_pop = load && w_last;

    // final word index of the head operation
    always_comb begin
        case (i_q_op.op)
            OP_LINE:  last_idx = LAST_IDX_LINE;
            OP_PAIR:  last_idx = LAST_IDX_PAIR;
            OP_PIXEL: last_idx = LAST_IDX_PIXEL;
            default:  last_idx = LAST_IDX_LINE;
        endcase
    end

    assign w_last = (r_idx == last_idx);

    // word selection
    always_comb begin
        w_is_data = 1'b1;
        w_byte    = 8'd0;
        if (i_q_op.op == OP_PAIR) begin
            case (r_idx)
                4'd0:    w_byte = i_q_op.c1[11:4];
                4'd1:    w_byte = {i_q_op.c1[3:0], i_q_op.c2[11:8]};
                default: w_byte = i_q_op.c2[7:0];
            endcase
        end else begin
            case (r_idx)
                W_PAGE_CMD: begin
                    w_is_data = 1'b0;
                    w_byte    = i_opc.page_set;
                end
                W_ROW_A, W_ROW_B: w_byte = i_q_op.row;
                W_COL_CMD: begin
                    w_is_data = 1'b0;
                    w_byte    = i_opc.col_set;
                end
                W_COL0:   w_byte = i_q_op.col0;
                W_COL1:   w_byte = i_q_op.col1;
                W_RAMWR: begin
                    w_is_data = 1'b0;
                    w_byte    = i_opc.ram_wr;
                end
                W_PIX_HI: w_byte = i_q_op.c1[11:4];
                W_PIX_LO: w_byte = {i_q_op.c1[3:0], 4'd0};
                W_NOP: begin
                    w_is_data = 1'b0;
                    w_byte    = i_opc.nop;
                end
                default:  w_byte = 8'd0;
            endcase
        end
    end

    // word counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 4'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= w_last ? 4'd0 : r_idx + 4'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_is_data <= w_is_data;
            r_byte    <= w_byte;
            r_last    <= w_last;
        end
    end

    assign o_valid   = r_valid;
    assign o_is_data = r_is_data;
    assign o_byte    = r_byte;
    assign o_last    = r_last;

    // the word counter only moves while an operation is queued
    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_valid |-> (r_idx == 4'd0))
        else $error("word counter off zero with empty queue");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_valid |-> (r_idx <= last_idx))
        else $error("word counter past end of operation");

endmodule

/* src/lcd_window_pixel_word_packer.sv */
// top level: 9-bit lcd controller word packer with apb register port
//
// channel   dir  beat contents
// s_axis    in   tuser[1:0] kind; tdata col_start, row_index, line_width,
//                first_color, second_color (48 bits)
// m_axis    out  tuser is_data; tdata out_byte; tlast last word of a request
// apb       in   regs at 0x0 page set, 0x4 column set, 0x8 ram write, 0xc nop
//
// output runs at one word per cycle, set by the back end's single output register,
// while m_axis_tready is high and an operation is queued
// the front end takes one request per cycle while the queue has room,
// dropped requests (bad width, pair with no line, unknown kind) are taken but queue nothing
// reset is synchronous: clears the line state, the queue and the output,
// and loads the default command bytes
// output stalls back up into the queue and then into s_axis_tready
`timescale 1ns / 1ps

module lcd_window_pixel_word_packer
    import lwpp_pkg::*;
#(
    parameter int QUEUE_DEPTH = Q_DEPTH
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // col_start, row_index, line_width, first_color, second_color
    input  logic [1:0]  s_axis_tuser,  // kind
    // word stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // out_byte
    output logic        m_axis_tuser,  // is_data
    output logic        m_axis_tlast,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       q_full;
    logic       q_push;
    t_op        q_in;
    logic       q_pop;
    logic       q_valid;
    t_op        q_out;
    t_opcodes   r_opc;
    logic       cfg_wr;
    logic [1:0] cfg_idx;

    // register port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opc.page_set <= RST_PAGE_SET;
            r_opc.col_set  <= RST_COL_SET;
            r_opc.ram_wr   <= RST_RAM_WR;
            r_opc.nop      <= RST_NOP;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_PAGE_SET: r_opc.page_set <= pwdata[7:0];
                REG_COL_SET:  r_opc.col_set  <= pwdata[7:0];
                REG_RAM_WR:   r_opc.ram_wr   <= pwdata[7:0];
                REG_NOP:      r_opc.nop      <= pwdata[7:0];
                default:      r_opc.nop      <= r_opc.nop;
            endcase
        end
    end

    // register read mux
    always_comb begin
        case (cfg_idx)
            REG_PAGE_SET: prdata = {24'd0, r_opc.page_set};
            REG_COL_SET:  prdata = {24'd0, r_opc.col_set};
            REG_RAM_WR:   prdata = {24'd0, r_opc.ram_wr};
            REG_NOP:      prdata = {24'd0, r_opc.nop};
            default:      prdata = 32'd0;
        endcase
    end

    lwpp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_kind  (s_axis_tuser),
        .i_data  (s_axis_tdata),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_op    (q_in)
    );

    lwpp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    lwpp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_opc     (r_opc),
        .i_q_valid (q_valid),
        .i_q_op    (q_out),
        .o_pop     (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_is_data (m_axis_tuser),
        .o_byte    (m_axis_tdata),
        .o_last    (m_axis_tlast)
    );

endmodule

/* sim/lcd_window_pixel_word_packer_tb.sv */
// testbench for the lcd window pixel word packer: directed and random requests, word checks
`timescale 1ns / 1ps

module lcd_window_pixel_word_packer_tb;
    import lwpp_pkg::*;

    // kind code that the block must ignore
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    // quiet cycles after the last expected word before moving on
    localparam int SETTLE_CYCLES = 24;
    localparam int DRAIN_GUARD   = 200000;

    // one controller word as seen on the output stream
    typedef struct {
        logic       is_data;
        logic [7:0] out_byte;
        logic       last;
    } t_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;  // col_start, row_index, line_width, first_color, second_color
    logic [1:0]  s_axis_tuser = '0;  // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;       // out_byte
    logic        m_axis_tuser;       // is_data
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // predictor state
    t_opcodes    opcodes;
    logic [7:0]  pairs_left;
    logic        line_open;
    t_word       expected_words[$];

    // traffic shaping
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    logic        rx_hold = 1'b0;

    // bookkeeping
    int          mismatch_count = 0;
    int          active_items = 0;
    int          dropped_items = 0;
    int          line_count = 0;
    int          pair_count = 0;
    int          pixel_count = 0;
    int          words_checked = 0;

    lcd_window_pixel_word_packer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // clock
    always #1 i_clk = ~i_clk;

    // run limit
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("tb: mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    function automatic logic [7:0] rand8();
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [11:0] rand12();
        return 12'($urandom_range(4095));
    endfunction

    function automatic void push_word(input logic is_data, input logic [7:0] value);
        t_word w;
        w.is_data  = is_data;
        w.out_byte = value;
        w.last     = 1'b0;
        expected_words.push_back(w);
    endfunction

    // page set, row twice, column set, start and end column, ram write
    function automatic void push_window(input logic [7:0] col0, input logic [7:0] col1,
                                        input logic [7:0] row);
        push_word(1'b0, opcodes.page_set);
        push_word(1'b1, row);
        push_word(1'b1, row);
        push_word(1'b0, opcodes.col_set);
        push_word(1'b1, col0);
        push_word(1'b1, col1);
        push_word(1'b0, opcodes.ram_wr);
    endfunction

    // expected words for one accepted request, updates the line state
    function automatic void predict_words(input logic [1:0] kind, input logic [7:0] col,
                                          input logic [7:0] row, input logic [7:0] width,
                                          input logic [11:0] c1, input logic [11:0] c2);
        int    before_count;
        t_word w;
        before_count = expected_words.size();
        case (kind)
            KIND_LINE: begin
                if (width != 8'd0 && int'(width) <= ROW_PIXELS) begin
                    push_window(col, col + width - 8'd1, row);
                    pairs_left = 8'((int'(width) + 1) >> 1);
                    line_open  = 1'b1;
                    line_count++;
                end
            end
            KIND_PAIR: begin
                if (line_open) begin
                    push_word(1'b1, c1[11:4]);
                    push_word(1'b1, {c1[3:0], c2[11:8]});
                    push_word(1'b1, c2[7:0]);
                    if (pairs_left != 8'd0) pairs_left = pairs_left - 8'd1;
                    if (pairs_left == 8'd0) line_open = 1'b0;
                    pair_count++;
                end
            end
            KIND_PIXEL: begin
                push_window(col, col, row);
                push_word(1'b1, c1[11:4]);
                push_word(1'b1, {c1[3:0], 4'b0000});
                push_word(1'b0, opcodes.nop);
                line_open  = 1'b0;
                pairs_left = 8'd0;
                pixel_count++;
            end
            default: ;
        endcase
        if (expected_words.size() > before_count) begin
            w = expected_words.pop_back();
            w.last = 1'b1;
            expected_words.push_back(w);
            active_items++;
        end else begin
            dropped_items++;
        end
    endfunction

    // one request beat, with random idle cycles before it
    task automatic send_item(input logic [1:0] kind, input logic [7:0] col,
                             input logic [7:0] row, input logic [7:0] width,
                             input logic [11:0] c1, input logic [11:0] c2);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {c2, c1, width, row, col};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_words(kind, col, row, width, c1, c2);
    endtask

    // register write: setup then access
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'h0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_PAGE_SET: opcodes.page_set = value;
            REG_COL_SET:  opcodes.col_set  = value;
            REG_RAM_WR:   opcodes.ram_wr   = value;
            REG_NOP:      opcodes.nop      = value;
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_opcodes(input logic [7:0] page_set, input logic [7:0] col_set,
                                input logic [7:0] ram_wr, input logic [7:0] nop);
        write_reg(REG_PAGE_SET, page_set);
        write_reg(REG_COL_SET, col_set);
        write_reg(REG_RAM_WR, ram_wr);
        write_reg(REG_NOP, nop);
    endtask

    // stop sending and wait until every expected word has come out
    task automatic drain(input int extra);
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0 && guard < DRAIN_GUARD) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (extra) @(posedge i_clk);
    endtask

    // long receiver hold-off, counted in its own process
    task automatic hold_receiver(input int cycles);
        rx_hold <= 1'b1;
        repeat (cycles) @(posedge i_clk);
        rx_hold <= 1'b0;
    endtask

    // output ready
    always @(posedge i_clk) begin
        m_axis_tready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // compare each output beat with the oldest expected word
    always @(posedge i_clk) begin
        t_word w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word data=%0b byte=%02h last=%0b",
                                          m_axis_tuser, m_axis_tdata, m_axis_tlast));
            end else begin
                w = expected_words.pop_front();
                words_checked++;
                if (m_axis_tuser !== w.is_data)
                    report_mismatch($sformatf("is_data %0b, expected %0b",
                                              m_axis_tuser, w.is_data));
                if (m_axis_tdata !== w.out_byte)
                    report_mismatch($sformatf("out_byte %02h, expected %02h",
                                              m_axis_tdata, w.out_byte));
                if (m_axis_tlast !== w.last)
                    report_mismatch($sformatf("last %0b, expected %0b",
                                              m_axis_tlast, w.last));
            end
        end
    end

    // window edges, bad widths, dropped pairs, replaced lines, unused kind
    task automatic test_directed_defaults();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // narrowest line, one pair of extreme colors
        send_item(KIND_LINE, 8'd0, 8'd0, 8'd1, 12'h000, 12'h000);
        send_item(KIND_PAIR, 8'hFF, 8'hFF, 8'hFF, 12'hFFF, 12'h000);
        // pair with no line open
        send_item(KIND_PAIR, 8'd0, 8'd0, 8'd0, 12'h123, 12'h456);
        // widest line with end column wrapping, cut short by a single pixel
        send_item(KIND_LINE, 8'hFF, 8'hFF, 8'(ROW_PIXELS), 12'hFFF, 12'hFFF);
        send_item(KIND_PAIR, 8'd0, 8'd0, 8'd0, 12'h000, 12'hFFF);
        send_item(KIND_PAIR, 8'd0, 8'd0, 8'd0, 12'hA5C, 12'h3E7);
        send_item(KIND_PIXEL, 8'hFF, 8'hFF, 8'd0, 12'hFFF, 12'hFFF);
        send_item(KIND_PAIR, 8'd1, 8'd1, 8'd1, 12'h111, 12'h222);
        // bad widths give nothing and leave no line open
        send_item(KIND_LINE, 8'd10, 8'd20, 8'd0, 12'h0, 12'h0);
        send_item(KIND_LINE, 8'd10, 8'd20, 8'(ROW_PIXELS + 1), 12'h0, 12'h0);
        send_item(KIND_LINE, 8'd10, 8'd20, 8'hFF, 12'h0, 12'h0);
        send_item(KIND_PAIR, 8'd0, 8'd0, 8'd0, 12'hFFF, 12'hFFF);
        // bad width while a line is open keeps that line
        send_item(KIND_LINE, 8'd5, 8'd6, 8'd2, 12'h0, 12'h0);
        send_item(KIND_LINE, 8'd5, 8'd6, 8'd0, 12'h0, 12'h0);
        send_item(KIND_PAIR, 8'd0, 8'd0, 8'd0, 12'h777, 12'h777);
        send_item(KIND_PAIR, 8'd0, 8'd0, 8'd0, 12'h888, 12'h999);
        // a new line start replaces an open line
        send_item(KIND_LINE, 8'd40, 8'd100, 8'd10, 12'h0, 12'h0);
        send_item(KIND_PAIR, 8'd0, 8'd0, 8'd0, 12'hF0F, 12'h0F0);
        send_item(KIND_LINE, 8'd200, 8'd131, 8'd3, 12'h0, 12'h0);
        send_item(KIND_PAIR, 8'd0, 8'd0, 8'd0, 12'hABC, 12'hDEF);
        send_item(KIND_PAIR, 8'd0, 8'd0, 8'd0, 12'h321, 12'h321);
        send_item(KIND_PAIR, 8'd0, 8'd0, 8'd0, 12'h555, 12'hAAA);
        // unused kind is ignored
        send_item(KIND_UNUSED, 8'hFF, 8'hFF, 8'd4, 12'hFFF, 12'hFFF);
        send_item(KIND_PIXEL, 8'd0, 8'd0, 8'hFF, 12'h000, 12'hFFF);
        drain(SETTLE_CYCLES);
    endtask

    task automatic short_line_and_pixel();
        send_item(KIND_LINE, rand8(), rand8(), 8'd3, rand12(), rand12());
        send_item(KIND_PAIR, rand8(), rand8(), rand8(), rand12(), rand12());
        send_item(KIND_PAIR, rand8(), rand8(), rand8(), rand12(), rand12());
        send_item(KIND_PIXEL, rand8(), rand8(), rand8(), rand12(), rand12());
    endtask

    // command bytes at both ends of their range
    task automatic test_opcode_extremes();
        load_opcodes(8'h00, 8'h00, 8'h00, 8'h00);
        short_line_and_pixel();
        drain(SETTLE_CYCLES);
        load_opcodes(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        short_line_and_pixel();
        drain(SETTLE_CYCLES);
    endtask

    // mostly complete lines with random content, plus noise and cut lines
    task automatic test_random_traffic(input int n_items, input int tx_pct, input int rx_pct);
        int          target;
        int          roll;
        int          w;
        int          k;
        logic [11:0] c;
        send_idle_pct = tx_pct;
        recv_idle_pct = rx_pct;
        target = active_items + n_items;
        while (active_items < target) begin
            roll = $urandom_range(99);
            if (roll < 70) begin
                w = ($urandom_range(9) == 0) ? $urandom_range(100, ROW_PIXELS)
                                             : $urandom_range(1, 12);
                send_item(KIND_LINE, rand8(), rand8(), 8'(w), rand12(), rand12());
                for (k = 0; k < (w + 1) / 2; k++) begin
                    if ($urandom_range(39) == 0) break;
                    c = rand12();
                    // every fifth pair or so is a solid fill
                    send_item(KIND_PAIR, rand8(), rand8(), rand8(), c,
                              ($urandom_range(4) == 0) ? c : rand12());
                end
            end else if (roll < 80) begin
                send_item(KIND_PIXEL, rand8(), rand8(), rand8(), rand12(), rand12());
            end else if (roll < 88) begin
                w = ($urandom_range(3) == 0) ? 0 : $urandom_range(ROW_PIXELS + 1, 255);
                send_item(KIND_LINE, rand8(), rand8(), 8'(w), rand12(), rand12());
            end else if (roll < 95) begin
                send_item(KIND_PAIR, rand8(), rand8(), rand8(), rand12(), rand12());
            end else begin
                send_item(KIND_UNUSED, rand8(), rand8(), rand8(), rand12(), rand12());
            end
        end
        drain(SETTLE_CYCLES);
    endtask

    // output held off while requests keep coming, input must back up
    task automatic test_backpressure();
        int n;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fork
            hold_receiver(300);
        join_none
        for (n = 0; n < 12; n++) begin
            send_item(KIND_LINE, rand8(), rand8(), 8'd4, rand12(), rand12());
            send_item(KIND_PAIR, rand8(), rand8(), rand8(), rand12(), rand12());
            send_item(KIND_PAIR, rand8(), rand8(), rand8(), rand12(), rand12());
        end
        drain(SETTLE_CYCLES);
    endtask

    initial begin
        opcodes.page_set = RST_PAGE_SET;
        opcodes.col_set  = RST_COL_SET;
        opcodes.ram_wr   = RST_RAM_WR;
        opcodes.nop      = RST_NOP;
        pairs_left       = 8'd0;
        line_open        = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_defaults();
        test_opcode_extremes();
        load_opcodes(rand8(), rand8(), rand8(), rand8());
        test_random_traffic(55, 38, 86);
        load_opcodes(rand8(), rand8(), rand8(), rand8());
        test_random_traffic(55, 86, 38);
        load_opcodes(RST_PAGE_SET, RST_COL_SET, RST_RAM_WR, RST_NOP);
        test_random_traffic(55, 0, 0);
        test_backpressure();

        if (expected_words.size() != 0)
            report_mismatch($sformatf("%0d expected words never arrived",
                                      expected_words.size()));
        $display("tb: %0d requests with output (%0d lines, %0d pairs, %0d pixels), %0d dropped",
                 active_items, line_count, pair_count, pixel_count, dropped_items);
        $display("tb: %0d words checked over several opcode sets, idle mixes and a long hold",
                 words_checked);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
